>>> hw/rtl/fwc_pkg.sv
// ----------------------------------------------------------------------------
// fwc_pkg: shared types and constants for the frequency weighting curve
// Curve codes, register indexes, log2 formats and elaboration-time helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package fwc_pkg;

  // log2 result: 6-bit integer part, 24-bit fraction
  localparam int LOG_FRAC = 24;
  localparam int LOG_W    = 30;
  localparam int CONST_FRAC = 16;

  // 20*log10(2) in Q24
  localparam longint DB_PER_OCT = 64'sd101008905;

  // curve codes
  localparam logic [2:0] CURVE_A = 3'd0;
  localparam logic [2:0] CURVE_B = 3'd1;
  localparam logic [2:0] CURVE_C = 3'd2;
  localparam logic [2:0] CURVE_D = 3'd3;
  localparam logic [2:0] CURVE_Z = 3'd4;

  // register indexes
  localparam logic [7:0] REG_CURVE_KIND = 8'd0;
  localparam logic [7:0] REG_MIN_WEIGHT = 8'd1;

  // dB offsets in Q24 (A, B, C)
  localparam longint OFF_A = 64'sd33554432;
  localparam longint OFF_B = 64'sd2852127;
  localparam longint OFF_C = 64'sd1040187;

  // sideband that travels with each item
  typedef struct packed {
    logic [2:0] kind;
    logic       zero;
    logic [5:0] sa;
    logic [5:0] sb;
  } meta_t;

  // log2 in Q24, evaluated on constants at elaboration
  function automatic logic [LOG_W-1:0] log2_fix(input logic [63:0] v);
    logic [5:0]  p;
    logic [63:0] m;
    logic [LOG_FRAC-1:0] fr;
    p = 6'd0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) p = i[5:0];
    end
    m = (p > 6'd30) ? (v >> (p - 6'd30)) : (v << (6'd30 - p));
    fr = '0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      fr = {fr[LOG_FRAC-2:0], m[31]};
      if (m[31]) m = m >> 1;
    end
    return {p, fr};
  endfunction

  // D-curve leading constant: 4*(log2(1e10) - log2(83046305))
  localparam longint LC0_D = 4 * (longint'(log2_fix(64'd10000000000))
                                - longint'(log2_fix(64'd83046305)));

endpackage
`default_nettype wire

>>> hw/rtl/frequency_weighting_curve_top.sv
// ----------------------------------------------------------------------------
// frequency_weighting_curve_top: A/B/C/D/Z perceptual weighting in dB
// Squares the frequency, forms the pole-zero terms, takes five log2 lanes in
// parallel and combines them into a Q8.8 weight clamped at min_weight, or 0 dB for Z.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the pipeline advances; the 24 squaring
// stages of each log2 lane set the depth. The whole pipeline advances when the
// output register is empty or taken. Synchronous active-low reset clears all
// valid bits, curve_kind to A and min_weight to -80 dB.
`default_nettype none
module frequency_weighting_curve_top
  import fwc_pkg::*;
#(
  parameter int FREQ_FRAC_BITS = 4,
  parameter int DB_FRAC_BITS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [20:0] frequency
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [16:0] weight
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int LAT  = 36;
  localparam int XW   = 48;
  localparam int SUMW = 40;
  localparam int AW   = 72;
  localparam int RSH  = 49 - DB_FRAC_BITS;
  localparam int SH   = CONST_FRAC - 2 * FREQ_FRAC_BITS;

  // squared constants in units of x, rounded at 16 bits then to x units
  localparam longint unsigned P_C0 = 64'd12194217 * 64'd12194217;
  localparam longint unsigned V_C0 = ((P_C0 / 64'd1000000) << 16)
    + (((P_C0 % 64'd1000000) << 16) + 64'd500000) / 64'd1000000;
  localparam longint unsigned SQ_C0 = (V_C0 + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_C1 = 64'd20598997 * 64'd20598997;
  localparam longint unsigned V_C1 = ((P_C1 / 64'd1000000000000) << 16)
    + (((P_C1 % 64'd1000000000000) << 16) + 64'd500000000000) / 64'd1000000000000;
  localparam longint unsigned SQ_C1 = (V_C1 + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_A1 = 64'd10765265 * 64'd10765265;
  localparam longint unsigned V_A1 = ((P_A1 / 64'd10000000000) << 16)
    + (((P_A1 % 64'd10000000000) << 16) + 64'd5000000000) / 64'd10000000000;
  localparam longint unsigned SQ_A1 = (V_A1 + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_A2 = 64'd73786223 * 64'd73786223;
  localparam longint unsigned V_A2 = ((P_A2 / 64'd10000000000) << 16)
    + (((P_A2 % 64'd10000000000) << 16) + 64'd5000000000) / 64'd10000000000;
  localparam longint unsigned SQ_A2 = (V_A2 + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_B1 = 64'd15848932 * 64'd15848932;
  localparam longint unsigned V_B1 = ((P_B1 / 64'd10000000000) << 16)
    + (((P_B1 % 64'd10000000000) << 16) + 64'd5000000000) / 64'd10000000000;
  localparam longint unsigned SQ_B1 = (V_B1 + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_DQ1C = 64'd10187 * 64'd10187;
  localparam longint unsigned V_DQ1C = ((P_DQ1C / 64'd100) << 16)
    + (((P_DQ1C % 64'd100) << 16) + 64'd50) / 64'd100;
  localparam longint unsigned SQ_DQ1C = (V_DQ1C + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_DQ1K = 64'd10396 * 64'd10396;
  localparam longint unsigned V_DQ1K = ((P_DQ1K / 64'd100) << 16)
    + (((P_DQ1K % 64'd100) << 16) + 64'd50) / 64'd100;
  localparam longint unsigned SQ_DQ1K = (V_DQ1K + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_DQ2C = 64'd31365 * 64'd31365;
  localparam longint unsigned V_DQ2C = ((P_DQ2C / 64'd100) << 16)
    + (((P_DQ2C % 64'd100) << 16) + 64'd50) / 64'd100;
  localparam longint unsigned SQ_DQ2C = (V_DQ2C + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned V_DQ2K = (64'd3424 * 64'd3424) << 16;
  localparam longint unsigned SQ_DQ2K = (V_DQ2K + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned P_D1 = 64'd2827 * 64'd2827;
  localparam longint unsigned V_D1 = ((P_D1 / 64'd100) << 16)
    + (((P_D1 % 64'd100) << 16) + 64'd50) / 64'd100;
  localparam longint unsigned SQ_D1 = (V_D1 + ((64'd1 << SH) >> 1)) >> SH;
  localparam longint unsigned V_D2 = (64'd1160 * 64'd1160) << 16;
  localparam longint unsigned SQ_D2 = (V_D2 + ((64'd1 << SH) >> 1)) >> SH;

  localparam longint LOG_C0 = longint'(log2_fix(SQ_C0));
  localparam longint FFB_Q  = longint'(2 * FREQ_FRAC_BITS) << LOG_FRAC;

  localparam logic [XW-1:0] C_DQ1C = SQ_DQ1C[XW-1:0];
  localparam logic [XW-1:0] C_DQ1K = SQ_DQ1K[XW-1:0];
  localparam logic [XW-1:0] C_DQ2C = SQ_DQ2C[XW-1:0];
  localparam logic [XW-1:0] C_DQ2K = SQ_DQ2K[XW-1:0];

  // configuration registers
  logic [2:0]         kind_r;
  logic signed [16:0] minw_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= CURVE_A;
      minw_r <= -17'sd20480;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CURVE_KIND) kind_r <= cfg_data[2:0];
      if (cfg_index == REG_MIN_WEIGHT) minw_r <= cfg_data;
    end
  end

  // pipeline advance: output register empty or taken
  logic adv;
  logic [LAT-1:0] vld_r;

  assign adv       = out_tready | ~vld_r[LAT-1];
  assign in_tready = adv;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // sideband delay line
  meta_t meta_r [0:LAT-2];
  meta_t meta_in;
  logic [5:0] sa_nxt, sb_nxt;

  always_comb begin
    meta_in.kind = kind_r;
    meta_in.zero = (in_tdata[20:0] == 21'd0);
    meta_in.sa   = '0;
    meta_in.sb   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta_in;
      for (int i = 1; i < LAT - 1; i++) begin
        if (i != 3) meta_r[i] <= meta_r[i-1];
      end
      // prescale shifts join the sideband at stage 3
      meta_r[3] <= {meta_r[2].kind, meta_r[2].zero, sa_nxt, sb_nxt};
    end
  end

  // stage 0/1: input register and square
  logic [20:0]   f_r;
  logic [XW-1:0] x1_r;
  logic [41:0]   fsq;

  assign fsq = 42'(f_r) * 42'(f_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r  <= in_tdata[20:0];
      x1_r <= XW'(fsq);
    end
  end

  // stage 2: distances and maxima for the two quadratic terms
  logic [XW-1:0] x2_r, da2_r, db2_r, ma2_r, mb2_r;
  logic [XW-1:0] da, db, ma, mb;

  always_comb begin
    da = (C_DQ1C >= x1_r) ? C_DQ1C - x1_r : x1_r - C_DQ1C;
    db = (C_DQ2C >= x1_r) ? C_DQ2C - x1_r : x1_r - C_DQ2C;
    ma = (da > x1_r) ? da : x1_r;
    if (C_DQ1K > ma) ma = C_DQ1K;
    mb = (db > x1_r) ? db : x1_r;
    if (C_DQ2K > mb) mb = C_DQ2K;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r  <= x1_r;
      da2_r <= da;
      db2_r <= db;
      ma2_r <= ma;
      mb2_r <= mb;
    end
  end

  // stage 3: scale all three operands below 2^31
  logic [XW-1:0] x3_r;
  logic [30:0]   dsa3_r, xsa3_r, ksa3_r, dsb3_r, xsb3_r, ksb3_r;
  logic [XW-1:0] t_dsa, t_xsa, t_ksa, t_dsb, t_xsb, t_ksb;

  always_comb begin
    sa_nxt = '0;
    sb_nxt = '0;
    for (int i = 31; i < XW; i++) begin
      if (ma2_r[i]) sa_nxt = 6'(i - 30);
      if (mb2_r[i]) sb_nxt = 6'(i - 30);
    end
    t_dsa = da2_r  >> sa_nxt;
    t_xsa = x2_r   >> sa_nxt;
    t_ksa = C_DQ1K >> sa_nxt;
    t_dsb = db2_r  >> sb_nxt;
    t_xsb = x2_r   >> sb_nxt;
    t_ksb = C_DQ2K >> sb_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x3_r   <= x2_r;
      dsa3_r <= t_dsa[30:0];
      xsa3_r <= t_xsa[30:0];
      ksa3_r <= t_ksa[30:0];
      dsb3_r <= t_dsb[30:0];
      xsb3_r <= t_xsb[30:0];
      ksb3_r <= t_ksb[30:0];
    end
  end

  // stage 4: quadratic products
  logic [XW-1:0] x4_r;
  logic [61:0]   pa1_r, pa2_r, pb1_r, pb2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      x4_r  <= x3_r;
      pa1_r <= dsa3_r * dsa3_r;
      pa2_r <= ksa3_r * xsa3_r;
      pb1_r <= dsb3_r * dsb3_r;
      pb2_r <= ksb3_r * xsb3_r;
    end
  end

  // stage 5: lane operands per curve
  logic [63:0] op_r [0:4];
  logic [63:0] xe;

  assign xe = 64'(x4_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r[0] <= xe;
      if (meta_r[4].kind == CURVE_D) begin
        op_r[1] <= 64'(pa1_r) + 64'(pa2_r);
        op_r[2] <= 64'(pb1_r) + 64'(pb2_r);
      end else begin
        op_r[1] <= xe + SQ_C0;
        op_r[2] <= xe + SQ_C1;
      end
      unique case (meta_r[4].kind)
        CURVE_A: begin
          op_r[3] <= xe + SQ_A1;
          op_r[4] <= xe + SQ_A2;
        end
        CURVE_B: begin
          op_r[3] <= xe + SQ_B1;
          op_r[4] <= '0;
        end
        CURVE_D: begin
          op_r[3] <= xe + SQ_D1;
          op_r[4] <= xe + SQ_D2;
        end
        default: begin
          op_r[3] <= '0;
          op_r[4] <= '0;
        end
      endcase
    end
  end

  // stages 6..31: log2 lanes
  logic [LOG_W-1:0] lg [0:4];

  for (genvar g = 0; g < 5; g++) begin : g_lane
    fwc_log2 u_log2 (
      .clk (clk),
      .en  (adv),
      .op  (op_r[g]),
      .lg  (lg[g])
    );
  end

  // stage 32: combine log terms (twice the log2 of the magnitude)
  logic signed [SUMW-1:0] l0, l1, l2, l3, l4, sum_nxt, sum_r;
  meta_t mc;

  assign mc = meta_r[31];
  assign l0 = SUMW'($signed({1'b0, lg[0]}));
  assign l1 = SUMW'($signed({1'b0, lg[1]}));
  assign l2 = SUMW'($signed({1'b0, lg[2]}));
  assign l3 = SUMW'($signed({1'b0, lg[3]}));
  assign l4 = SUMW'($signed({1'b0, lg[4]}));

  always_comb begin
    unique case (mc.kind)
      CURVE_A: sum_nxt = SUMW'(2 * LOG_C0) - 2 * l1 - 2 * l2 + 4 * l0 - l3 - l4;
      CURVE_B: sum_nxt = SUMW'(2 * LOG_C0) - 2 * l1 - 2 * l2 + 3 * l0 - l3;
      CURVE_C: sum_nxt = SUMW'(2 * LOG_C0) - 2 * l1 - 2 * l2 + 2 * l0;
      CURVE_D: sum_nxt = l0 + SUMW'(LC0_D) + l1 - l2 - l3 - l4 + SUMW'(FFB_Q)
                       + (SUMW'(mc.sa) << (LOG_FRAC + 1))
                       - (SUMW'(mc.sb) << (LOG_FRAC + 1));
      default: sum_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) sum_r <= sum_nxt;
  end

  // stage 33: scale to dB
  logic signed [AW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (adv) acc_r <= AW'(sum_r) * AW'(DB_PER_OCT);
  end

  // stage 34: add offset and round half up
  logic signed [AW-1:0] off, rsum;
  logic signed [SUMW-1:0] w34_r;

  always_comb begin
    unique case (meta_r[33].kind)
      CURVE_A: off = AW'(OFF_A) <<< 25;
      CURVE_B: off = AW'(OFF_B) <<< 25;
      CURVE_C: off = AW'(OFF_C) <<< 25;
      default: off = '0;
    endcase
    rsum = acc_r + off + (AW'(1) <<< (RSH - 1));
  end

  always_ff @(posedge clk) begin
    if (adv) w34_r <= SUMW'(rsum >>> RSH);
  end

  // stage 35: clamp, special cases and saturation
  logic signed [SUMW-1:0] w_sel;
  logic [16:0] w35_r;
  meta_t mo;

  assign mo = meta_r[34];

  always_comb begin
    if (mo.kind > CURVE_D) begin
      w_sel = '0;
    end else if (mo.zero || (w34_r < SUMW'(minw_r))) begin
      w_sel = SUMW'(minw_r);
    end else begin
      w_sel = w34_r;
    end
    if (w_sel > SUMW'(65535)) w_sel = SUMW'(65535);
    if (w_sel < -SUMW'(65536)) w_sel = -SUMW'(65536);
  end

  always_ff @(posedge clk) begin
    if (adv) w35_r <= w_sel[16:0];
  end

  assign out_tdata = {7'd0, w35_r};

endmodule
`default_nettype wire

>>> hw/rtl/fwc_log2.sv
// ----------------------------------------------------------------------------
// fwc_log2: pipelined fixed-point log2
// Leading-one search, normalize to Q1.30, then one squaring step per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fwc_log2
  import fwc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [63:0]       op,
  output logic      [LOG_W-1:0]  lg
);

  logic [63:0] v_r;
  logic [5:0]  p0_r;
  logic [5:0]  p_nxt;
  logic [30:0] m_r    [0:LOG_FRAC];
  logic [5:0]  p_r    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] fr_r [0:LOG_FRAC];
  logic [63:0] shl;

  // leading-one position
  always_comb begin
    p_nxt = 6'd0;
    for (int i = 1; i < 64; i++) begin
      if (op[i]) p_nxt = i[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= op;
      p0_r <= p_nxt;
    end
  end

  // normalize mantissa into [2^30, 2^31)
  assign shl = (p0_r > 6'd30) ? (v_r >> (p0_r - 6'd30)) : (v_r << (6'd30 - p0_r));

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= shl[30:0];
      p_r[0]  <= p0_r;
      fr_r[0] <= '0;
    end
  end

  // one result bit per stage
  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = m_r[g] * m_r[g];
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[g+1]  <= t[31] ? t[31:1] : t[30:0];
        p_r[g+1]  <= p_r[g];
        fr_r[g+1] <= {fr_r[g][LOG_FRAC-2:0], t[31]};
      end
    end
  end

  assign lg = {p_r[LOG_FRAC], fr_r[LOG_FRAC]};

endmodule
`default_nettype wire
